FILE: rtl/core/serial_port_ring_buffers_macros.svh
// Assertion macros for the serial port ring buffers block
`ifndef SERIAL_PORT_RING_BUFFERS_MACROS_SVH
`define SERIAL_PORT_RING_BUFFERS_MACROS_SVH

// Assert on an explicit clock and active-low reset
`define SPR_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("serial_port_ring_buffers: assertion failed");

// Assert on the block clock and reset
`define SPR_ASSERT(lbl, prop) \
  `SPR_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/spr_pkg.sv
// Shared types and constants for the serial port ring buffers
`default_nettype none

package spr_pkg;

  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int COUNT_MAX = 255;

  localparam logic [SIZE_W-1:0] RX_SIZE_RESET    = 9'd256;
  localparam logic [DATA_W-1:0] BREAK_KEY_RESET  = 8'd0;
  localparam logic              CONSOLE_RESET    = 1'b0;
  localparam int                RX_SIZE_MIN      = 2;

  localparam logic [1:0] REG_RX_SIZE      = 2'd0;
  localparam logic [1:0] REG_BREAK_KEY    = 2'd1;
  localparam logic [1:0] REG_CONSOLE_MODE = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RX_BYTE    = 2'd0,
    FUNC_HOST_READ  = 2'd1,
    FUNC_HOST_WRITE = 2'd2,
    FUNC_LINE_READY = 2'd3
  } func_e;

endpackage

`default_nettype wire

FILE: rtl/core/spr_if.sv
// Request and response channel interfaces for the serial port ring buffers
`default_nettype none

interface spr_req_if;
  logic                          valid;
  logic                          ready;
  logic [spr_pkg::FUNC_W-1:0]    func;
  logic [spr_pkg::DATA_W-1:0]    data_in;

  modport source (output valid, func, data_in, input ready);
  modport sink   (input valid, func, data_in, output ready);
endinterface

interface spr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spr_pkg::DATA_W-1:0]    data_out;
  logic                          data_valid;
  logic                          tx_refused;
  logic                          abort_seen;
  logic                          tx_idle;
  logic [spr_pkg::COUNT_W-1:0]   rx_count;
  logic [spr_pkg::COUNT_W-1:0]   tx_count;

  modport source (output valid, data_out, data_valid, tx_refused, abort_seen, tx_idle,
                  rx_count, tx_count, input ready);
  modport sink   (input valid, data_out, data_valid, tx_refused, abort_seen, tx_idle,
                  rx_count, tx_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/serial_port_ring_buffers.sv
// Serial port receive and transmit rings with host and line access
//
//   channel  dir  handshake        payload
//   req_i    in   valid/ready      func, data_in
//   rsp_o    out  valid/ready      data_out, flags, rx_count, tx_count
//   apb      in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One request per cycle while results are taken; a result passes through the input
// register, then the result register with the ring read register.
// The pointer update and ring access for a request happen in the same cycle.
// Reset clears the pointers, valid flags and settings; ring contents and data registers are not cleared.
// A stalled result holds; the input register then fills and ready drops.
`default_nettype none
`include "serial_port_ring_buffers_macros.svh"

module serial_port_ring_buffers #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  spr_req_if.sink                           req_i,
  spr_rsp_if.source                         rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spr_pkg::APB_AW-1:0]   paddr,
  input  wire logic [spr_pkg::APB_DW-1:0]   pwdata,
  output logic      [spr_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_CW = RX_AW + 1;
  localparam int TX_CW = TX_AW + 1;
  localparam int RX_SIZE_RST_INT = (RX_DEPTH < int'(spr_pkg::RX_SIZE_RESET)) ?
                                   RX_DEPTH : int'(spr_pkg::RX_SIZE_RESET);
  localparam logic [RX_CW-1:0] RX_SIZE_RST = RX_CW'(RX_SIZE_RST_INT);
  localparam logic [TX_AW-1:0] TX_LAST     = TX_AW'(TX_DEPTH - 1);
  localparam logic [TX_CW-1:0] TX_SIZE     = TX_CW'(TX_DEPTH);

  // configuration
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;
  logic [spr_pkg::SIZE_W-1:0]    rx_size_raw_q;
  logic [RX_CW-1:0]              rx_size_q, rx_size_d;
  logic [spr_pkg::DATA_W-1:0]    break_key_q;
  logic                          console_q;
  logic [31:0]                   wsize;

  // pipeline
  logic                          s1_valid_q;
  logic [spr_pkg::FUNC_W-1:0]    s1_func_q;
  logic [spr_pkg::DATA_W-1:0]    s1_data_q;
  logic                          rsp_valid_q;
  logic                          rsp_take, s1_adv, in_take;

  // ring pointers
  logic [RX_AW-1:0]              rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [TX_AW-1:0]              tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [RX_AW-1:0]              rx_last, rx_next_head, rx_next_tail;
  logic [TX_AW-1:0]              tx_next_head, tx_next_tail;
  logic                          rx_empty, tx_empty, tx_full, is_break;
  logic                          rx_we, tx_we;

  // result
  logic                          dv_d, refused_d, abort_d, idle_d, src_tx_d;
  logic                          dv_q, refused_q, abort_q, idle_q, src_tx_q;
  logic [RX_CW-1:0]              rx_diff, rx_fill;
  logic [TX_CW-1:0]              tx_diff, tx_fill;
  logic [spr_pkg::COUNT_W-1:0]   rx_cnt_d, tx_cnt_d, rx_cnt_q, tx_cnt_q;
  logic [spr_pkg::DATA_W-1:0]    rx_rd_q, tx_rd_q;

  logic [spr_pkg::DATA_W-1:0]    rx_mem [RX_DEPTH];
  logic [spr_pkg::DATA_W-1:0]    tx_mem [TX_DEPTH];

  // APB port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign wsize   = 32'(pwdata[spr_pkg::SIZE_W-1:0]);

  always_comb begin
    if (wsize < 32'(spr_pkg::RX_SIZE_MIN)) begin
      rx_size_d = RX_CW'(spr_pkg::RX_SIZE_MIN);
    end else if (wsize > 32'(RX_DEPTH)) begin
      rx_size_d = RX_CW'(RX_DEPTH);
    end else begin
      rx_size_d = RX_CW'(wsize);
    end
  end

  always_comb begin
    unique case (cfg_idx)
      spr_pkg::REG_RX_SIZE:      prdata = spr_pkg::APB_DW'(rx_size_raw_q);
      spr_pkg::REG_BREAK_KEY:    prdata = spr_pkg::APB_DW'(break_key_q);
      spr_pkg::REG_CONSOLE_MODE: prdata = spr_pkg::APB_DW'(console_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_size_raw_q <= spr_pkg::RX_SIZE_RESET;
      rx_size_q     <= RX_SIZE_RST;
      break_key_q   <= spr_pkg::BREAK_KEY_RESET;
      console_q     <= spr_pkg::CONSOLE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        spr_pkg::REG_RX_SIZE: begin
          rx_size_raw_q <= pwdata[spr_pkg::SIZE_W-1:0];
          rx_size_q     <= rx_size_d;
        end
        spr_pkg::REG_BREAK_KEY:    break_key_q <= pwdata[spr_pkg::DATA_W-1:0];
        spr_pkg::REG_CONSOLE_MODE: console_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign rsp_take    = rsp_valid_q && rsp_o.ready;
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_take);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_func_q <= req_i.func;
      s1_data_q <= req_i.data_in;
    end
  end

  // ring control
  assign rx_last      = RX_AW'(rx_size_q - RX_CW'(1));
  assign rx_next_head = (rx_head_q == rx_last) ? '0 : rx_head_q + 1'b1;
  assign rx_next_tail = (rx_tail_q == rx_last) ? '0 : rx_tail_q + 1'b1;
  assign tx_next_head = (tx_head_q == TX_LAST) ? '0 : tx_head_q + 1'b1;
  assign tx_next_tail = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + 1'b1;
  assign rx_empty     = rx_head_q == rx_tail_q;
  assign tx_empty     = tx_head_q == tx_tail_q;
  assign tx_full      = tx_next_head == tx_tail_q;
  assign is_break     = console_q && (break_key_q != '0) && (s1_data_q == break_key_q);

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    dv_d      = 1'b0;
    refused_d = 1'b0;
    abort_d   = 1'b0;
    idle_d    = 1'b0;
    src_tx_d  = 1'b0;
    if (s1_adv) begin
      unique case (spr_pkg::func_e'(s1_func_q))
        spr_pkg::FUNC_RX_BYTE: begin
          if (is_break) begin
            abort_d   = 1'b1;
            rx_head_d = rx_tail_q;
          end else begin
            rx_we     = 1'b1;
            rx_head_d = rx_next_head;
            // drop the oldest byte on overflow
            if (rx_next_head == rx_tail_q) begin
              rx_tail_d = rx_next_tail;
            end
          end
        end
        spr_pkg::FUNC_HOST_READ: begin
          if (!rx_empty) begin
            dv_d      = 1'b1;
            rx_tail_d = rx_next_tail;
          end
        end
        spr_pkg::FUNC_HOST_WRITE: begin
          if (tx_full) begin
            refused_d = 1'b1;
          end else begin
            tx_we     = 1'b1;
            tx_head_d = tx_next_head;
          end
        end
        spr_pkg::FUNC_LINE_READY: begin
          src_tx_d = 1'b1;
          if (!tx_empty) begin
            dv_d      = 1'b1;
            tx_tail_d = tx_next_tail;
          end else begin
            idle_d = 1'b1;
          end
        end
      endcase
    end
    if (cfg_wr && cfg_idx == spr_pkg::REG_RX_SIZE) begin
      rx_head_d = '0;
      rx_tail_d = '0;
    end
  end

  // fill counts after this request
  always_comb begin
    rx_diff  = {1'b0, rx_head_d} - {1'b0, rx_tail_d};
    rx_fill  = rx_diff[RX_AW] ? rx_diff + rx_size_q : rx_diff;
    tx_diff  = {1'b0, tx_head_d} - {1'b0, tx_tail_d};
    tx_fill  = tx_diff[TX_AW] ? tx_diff + TX_SIZE : tx_diff;
    rx_cnt_d = (32'(rx_fill) > 32'(spr_pkg::COUNT_MAX)) ?
               spr_pkg::COUNT_W'(spr_pkg::COUNT_MAX) : spr_pkg::COUNT_W'(rx_fill);
    tx_cnt_d = (32'(tx_fill) > 32'(spr_pkg::COUNT_MAX)) ?
               spr_pkg::COUNT_W'(spr_pkg::COUNT_MAX) : spr_pkg::COUNT_W'(tx_fill);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
    end
  end

  // ring storage
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_head_q] <= s1_data_q;
    end
    if (s1_adv) begin
      rx_rd_q <= rx_mem[rx_tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_head_q] <= s1_data_q;
    end
    if (s1_adv) begin
      tx_rd_q <= tx_mem[tx_tail_q];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      dv_q      <= dv_d;
      refused_q <= refused_d;
      abort_q   <= abort_d;
      idle_q    <= idle_d;
      src_tx_q  <= src_tx_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_cnt_q  <= tx_cnt_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.data_out   = dv_q ? (src_tx_q ? tx_rd_q : rx_rd_q) : '0;
  assign rsp_o.data_valid = dv_q;
  assign rsp_o.tx_refused = refused_q;
  assign rsp_o.abort_seen = abort_q;
  assign rsp_o.tx_idle    = idle_q;
  assign rsp_o.rx_count   = rx_cnt_q;
  assign rsp_o.tx_count   = tx_cnt_q;

  `SPR_ASSERT(a_rx_ptr_range, (rx_head_q <= rx_last) && (rx_tail_q <= rx_last))
  `SPR_ASSERT(a_flags_exclusive,
              rsp_valid_q |-> $onehot0({dv_q, refused_q, abort_q, idle_q}))
  `SPR_ASSERT(a_refused_holds_tx,
              (s1_adv && s1_func_q == spr_pkg::FUNC_HOST_WRITE && tx_full)
              |=> ($stable(tx_head_q) && $stable(tx_tail_q)))
  `SPR_ASSERT_CLK(a_adv_fills_rsp, clk_i, rst_ni, s1_adv |=> rsp_valid_q)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for the serial port ring buffers: shadow rings predict every status result
module tb;

  localparam int RX_DEPTH       = 256;
  localparam int TX_DEPTH       = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [spr_pkg::DATA_W-1:0]  data_out;
    logic                        data_valid;
    logic                        tx_refused;
    logic                        abort_seen;
    logic                        tx_idle;
    logic [spr_pkg::COUNT_W-1:0] rx_count;
    logic [spr_pkg::COUNT_W-1:0] tx_count;
  } status_t;

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [spr_pkg::APB_AW-1:0] paddr;
  logic [spr_pkg::APB_DW-1:0] pwdata;
  logic [spr_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  spr_req_if req_if();
  spr_rsp_if rsp_if();

  serial_port_ring_buffers #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  logic [spr_pkg::DATA_W-1:0] rx_mem [RX_DEPTH];
  logic [spr_pkg::DATA_W-1:0] tx_mem [TX_DEPTH];
  int                         rx_wr, rx_rd, tx_wr, tx_rd;
  logic [spr_pkg::SIZE_W-1:0] cfg_rx_size;
  logic [spr_pkg::DATA_W-1:0] cfg_break;
  logic                       cfg_console;

  status_t status_q[$];
  int      mismatches;
  bit      idle_on;
  int      hold_len;
  int      hold_left;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [spr_pkg::COUNT_W-1:0] ring_fill(int wr, int rd, int size);
    int n;
    n = (wr >= rd) ? wr - rd : wr + size - rd;
    return spr_pkg::COUNT_W'((n > spr_pkg::COUNT_MAX) ? spr_pkg::COUNT_MAX : n);
  endfunction

  function automatic status_t predict_status(spr_pkg::func_e f,
                                             logic [spr_pkg::DATA_W-1:0] d);
    status_t s;
    int      rs;
    int      nxt;
    s  = '0;
    rs = (cfg_rx_size < spr_pkg::RX_SIZE_MIN) ? spr_pkg::RX_SIZE_MIN :
         (cfg_rx_size > RX_DEPTH) ? RX_DEPTH : int'(cfg_rx_size);
    rx_wr = rx_wr % rs;
    rx_rd = rx_rd % rs;
    case (f)
      spr_pkg::FUNC_RX_BYTE: begin
        if (cfg_console && cfg_break != 0 && d == cfg_break) begin
          s.abort_seen = 1'b1;
          rx_wr = rx_rd;
        end else begin
          rx_mem[rx_wr] = d;
          rx_wr = (rx_wr + 1) % rs;
          if (rx_wr == rx_rd) rx_rd = (rx_rd + 1) % rs;
        end
      end
      spr_pkg::FUNC_HOST_READ: begin
        if (rx_wr != rx_rd) begin
          s.data_out   = rx_mem[rx_rd];
          s.data_valid = 1'b1;
          rx_rd = (rx_rd + 1) % rs;
        end
      end
      spr_pkg::FUNC_HOST_WRITE: begin
        nxt = (tx_wr + 1) % TX_DEPTH;
        if (nxt == tx_rd) begin
          s.tx_refused = 1'b1;
        end else begin
          tx_mem[tx_wr] = d;
          tx_wr = nxt;
        end
      end
      default: begin
        if (tx_wr != tx_rd) begin
          s.data_out   = tx_mem[tx_rd];
          s.data_valid = 1'b1;
          tx_rd = (tx_rd + 1) % TX_DEPTH;
        end else begin
          s.tx_idle = 1'b1;
        end
      end
    endcase
    s.rx_count = ring_fill(rx_wr, rx_rd, rs);
    s.tx_count = ring_fill(tx_wr, tx_rd, TX_DEPTH);
    return s;
  endfunction

  task automatic report(string msg);
    if (mismatches < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_status
    status_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (status_q.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = status_q.pop_front();
        check_field("data_out", rsp_if.data_out, want.data_out);
        check_field("data_valid", 8'(rsp_if.data_valid), 8'(want.data_valid));
        check_field("tx_refused", 8'(rsp_if.tx_refused), 8'(want.tx_refused));
        check_field("abort_seen", 8'(rsp_if.abort_seen), 8'(want.abort_seen));
        check_field("tx_idle", 8'(rsp_if.tx_idle), 8'(want.tx_idle));
        check_field("rx_count", rsp_if.rx_count, want.rx_count);
        check_field("tx_count", rsp_if.tx_count, want.tx_count);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic send_req(spr_pkg::func_e f, logic [spr_pkg::DATA_W-1:0] d);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_if.valid   = 1'b1;
    req_if.func    = f;
    req_if.data_in = d;
    do @(posedge clk); while (!req_if.ready);
    status_q.push_back(predict_status(f, d));
    @(negedge clk);
  endtask

  // drop valid, drain every pending result, then let the pipeline empty
  task automatic settle();
    req_if.valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_csr(logic [1:0] idx, logic [spr_pkg::APB_DW-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      spr_pkg::REG_RX_SIZE: begin
        cfg_rx_size = val[spr_pkg::SIZE_W-1:0];
        rx_wr = 0;
        rx_rd = 0;
      end
      spr_pkg::REG_BREAK_KEY:    cfg_break   = val[spr_pkg::DATA_W-1:0];
      spr_pkg::REG_CONSOLE_MODE: cfg_console = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_settings(int size, logic [spr_pkg::DATA_W-1:0] key, logic console);
    settle();
    write_csr(spr_pkg::REG_RX_SIZE, spr_pkg::APB_DW'(size));
    write_csr(spr_pkg::REG_BREAK_KEY, spr_pkg::APB_DW'(key));
    write_csr(spr_pkg::REG_CONSOLE_MODE, spr_pkg::APB_DW'(console));
  endtask

  function automatic spr_pkg::func_e pick_func(int w_rx, int w_rd, int w_wr, int w_rdy);
    int r;
    r = $urandom_range(0, w_rx + w_rd + w_wr + w_rdy - 1);
    if (r < w_rx) return spr_pkg::FUNC_RX_BYTE;
    if (r < w_rx + w_rd) return spr_pkg::FUNC_HOST_READ;
    if (r < w_rx + w_rd + w_wr) return spr_pkg::FUNC_HOST_WRITE;
    return spr_pkg::FUNC_LINE_READY;
  endfunction

  task automatic run_traffic(int n, int w_rx, int w_rd, int w_wr, int w_rdy);
    spr_pkg::func_e             f;
    logic [spr_pkg::DATA_W-1:0] d;
    repeat (n) begin
      f = pick_func(w_rx, w_rd, w_wr, w_rdy);
      d = 8'($urandom_range(0, 255));
      if (f == spr_pkg::FUNC_RX_BYTE && cfg_console && $urandom_range(0, 7) == 0) begin
        d = cfg_break;
      end
      send_req(f, d);
    end
  endtask

  task automatic test_basic_ops();
    send_req(spr_pkg::FUNC_HOST_READ, 8'h00);
    send_req(spr_pkg::FUNC_LINE_READY, 8'hFF);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'h00);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'hFF);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'hA5);
    send_req(spr_pkg::FUNC_HOST_READ, 8'hFF);
    send_req(spr_pkg::FUNC_HOST_READ, 8'h00);
    send_req(spr_pkg::FUNC_HOST_READ, 8'h5A);
    send_req(spr_pkg::FUNC_HOST_READ, 8'hFF);
    send_req(spr_pkg::FUNC_HOST_WRITE, 8'h00);
    send_req(spr_pkg::FUNC_HOST_WRITE, 8'hFF);
    send_req(spr_pkg::FUNC_HOST_WRITE, 8'h5A);
    send_req(spr_pkg::FUNC_LINE_READY, 8'h00);
    send_req(spr_pkg::FUNC_LINE_READY, 8'hFF);
    send_req(spr_pkg::FUNC_LINE_READY, 8'h00);
    send_req(spr_pkg::FUNC_LINE_READY, 8'h00);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'h03);
    send_req(spr_pkg::FUNC_HOST_READ, 8'h00);
  endtask

  task automatic test_ring_sizes();
    int sizes[6];
    sizes = '{0, 1, 2, 3, 7, 511};
    foreach (sizes[i]) begin
      apply_settings(sizes[i], 8'h00, 1'b0);
      run_traffic(30, 4, 2, 1, 1);
    end
  endtask

  // overflow the receive ring and fill the transmit ring until writes are refused
  task automatic test_fill_both_rings();
    apply_settings(RX_DEPTH, 8'h00, 1'b0);
    repeat (TX_DEPTH + 2) begin
      send_req(spr_pkg::FUNC_RX_BYTE, 8'($urandom_range(0, 255)));
      send_req(spr_pkg::FUNC_HOST_WRITE, 8'($urandom_range(0, 255)));
    end
    run_traffic(40, 1, 3, 1, 3);
  endtask

  task automatic test_break_key();
    apply_settings(20, 8'hFF, 1'b1);
    run_traffic(60, 4, 1, 1, 1);
    apply_settings(RX_DEPTH, 8'($urandom_range(1, 254)), 1'b1);
    run_traffic(60, 4, 1, 1, 1);
    apply_settings(RX_DEPTH, 8'h00, 1'b1);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'h00);
    run_traffic(20, 2, 2, 1, 1);
    apply_settings(RX_DEPTH, 8'h1B, 1'b0);
    send_req(spr_pkg::FUNC_RX_BYTE, 8'h1B);
    send_req(spr_pkg::FUNC_HOST_READ, 8'h00);
  endtask

  // hold off results long enough that the block stalls its input
  task automatic test_backpressure();
    settle();
    hold_len = HOLD_CYCLES;
    run_traffic(60, 1, 1, 1, 1);
  endtask

  task automatic test_mixed_settings();
    apply_settings(RX_DEPTH, 8'h00, 1'b0);
    run_traffic(40, 3, 3, 2, 2);
    apply_settings(5, 8'h1B, 1'b1);
    run_traffic(40, 3, 3, 2, 2);
    apply_settings(511, 8'hFF, 1'b1);
    run_traffic(40, 3, 3, 2, 2);
    apply_settings(2, 8'h01, 1'b1);
    run_traffic(40, 3, 3, 2, 2);
    apply_settings(100, 8'h80, 1'b0);
    run_traffic(40, 3, 3, 2, 2);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    run_traffic(100, 1, 1, 1, 1);
  endtask

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = spr_pkg::FUNC_RX_BYTE;
    req_if.data_in = '0;
    rsp_if.ready   = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    foreach (rx_mem[i]) rx_mem[i] = '0;
    foreach (tx_mem[i]) tx_mem[i] = '0;
    rx_wr          = 0;
    rx_rd          = 0;
    tx_wr          = 0;
    tx_rd          = 0;
    cfg_rx_size    = spr_pkg::RX_SIZE_RESET;
    cfg_break      = spr_pkg::BREAK_KEY_RESET;
    cfg_console    = spr_pkg::CONSOLE_RESET;
    mismatches     = 0;
    idle_on        = 1'b1;
    hold_len       = 0;
    hold_left      = 0;
    stall_left     = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_ring_sizes();
    test_fill_both_rings();
    test_break_key();
    test_backpressure();
    test_mixed_settings();
    test_no_idle();

    req_if.valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/spr_pkg.sv
rtl/core/spr_if.sv
rtl/core/serial_port_ring_buffers.sv
tb/tb.sv
